[sv/kqvp_pkg.sv]
package kqvp_pkg;

	// Fixed width of the character field.
	localparam int CHAR_W = 8;

	// Default buffer sizes.
	localparam int KEY_MAX_DFLT   = 16;
	localparam int VALUE_MAX_DFLT = 32;

	// Characters with a meaning to the parser.
	localparam logic [CHAR_W-1:0] CH_NUL       = 8'h00;
	localparam logic [CHAR_W-1:0] CH_EQUALS    = 8'h3D;
	localparam logic [CHAR_W-1:0] CH_QUOTE     = 8'h27;
	localparam logic [CHAR_W-1:0] CH_BACKSLASH = 8'h5C;

	// Parser phases, plus the readout of a finished pair.
	typedef enum logic [2:0] {
		PH_INIT  = 3'd0,
		PH_KEY   = 3'd1,
		PH_SEP   = 3'd2,
		PH_EQ    = 3'd3,
		PH_VALUE = 3'd4,
		PH_ESC   = 3'd5,
		PH_EMIT  = 3'd6
	} phase_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;
		logic put_key;
		logic put_val;
		logic rd_en;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_nul;
		logic is_alnum;
		logic is_ws;
		logic is_eq;
		logic is_quote;
		logic is_bslash;
		logic rd_free;
		logic rd_last;
	} sts_t;

	// Whitespace is tab through carriage return, and space.
	function automatic logic is_ws(input logic [CHAR_W-1:0] c);
		return c inside {8'd32, [8'd9:8'd13]};
	endfunction

	// ASCII letters and digits only.
	function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
		return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
	endfunction

endpackage

[sv/kqvp_char_if.sv]
interface kqvp_char_if;
	import kqvp_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;

	modport source (output valid, output char_code, input ready);
	modport sink (input valid, input char_code, output ready);
endinterface

[sv/kqvp_pair_if.sv]
interface kqvp_pair_if;
	import kqvp_pkg::*;

	logic              valid;
	logic              ready;
	logic              part;
	logic [CHAR_W-1:0] data_byte;
	logic              last;
	logic              truncated;

	modport source (output valid, output part, output data_byte, output last,
		output truncated, input ready);
	modport sink (input valid, input part, input data_byte, input last,
		input truncated, output ready);
endinterface

[sv/kqvp_ram.sv]
module kqvp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                          wr_data,
	input  logic                                      rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                          rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port; read data holds between reads.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

[sv/kqvp_ctrl.sv]
module kqvp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          char_valid,
	output logic          char_ready,
	input  kqvp_pkg::sts_t st,
	output kqvp_pkg::cmd_t cmd
);
	import kqvp_pkg::*;

	phase_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PH_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		char_ready = (state_q != PH_EMIT);
		if (state_q == PH_EMIT) begin
			// Read out one buffered byte whenever the output side has room.
			cmd.rd_en = st.rd_free;
			if (st.rd_free && st.rd_last) begin
				cmd.clear = 1'b1;
				state_d   = PH_INIT;
			end
		end else if (char_valid) begin
			if (st.is_nul) begin
				// End of string drops whatever pair is in progress.
				cmd.clear = 1'b1;
				state_d   = PH_INIT;
			end else begin
				case (state_q)
					PH_INIT: begin
						if (st.is_alnum) begin
							cmd.put_key = 1'b1;
							state_d     = PH_KEY;
						end
					end
					PH_KEY: begin
						if (st.is_alnum) begin
							cmd.put_key = 1'b1;
						end else if (st.is_ws) begin
							state_d = PH_SEP;
						end else if (st.is_eq) begin
							state_d = PH_EQ;
						end else begin
							cmd.clear = 1'b1;
							state_d   = PH_INIT;
						end
					end
					PH_SEP: begin
						if (st.is_eq) begin
							state_d = PH_EQ;
						end else if (!st.is_ws) begin
							cmd.clear = 1'b1;
							state_d   = PH_INIT;
						end
					end
					PH_EQ: begin
						if (st.is_quote) begin
							state_d = PH_VALUE;
						end else if (!st.is_ws) begin
							cmd.clear = 1'b1;
							state_d   = PH_INIT;
						end
					end
					PH_VALUE: begin
						if (st.is_bslash) begin
							state_d = PH_ESC;
						end else if (st.is_quote) begin
							state_d = PH_EMIT;
						end else begin
							cmd.put_val = 1'b1;
						end
					end
					PH_ESC: begin
						// The escaped character is taken literally.
						cmd.put_val = 1'b1;
						state_d     = PH_VALUE;
					end
					default: begin
						cmd.clear = 1'b1;
						state_d   = PH_INIT;
					end
				endcase
			end
		end
	end
endmodule

[sv/kqvp_dp.sv]
module kqvp_dp #(
	parameter int KEY_MAX   = kqvp_pkg::KEY_MAX_DFLT,
	parameter int VALUE_MAX = kqvp_pkg::VALUE_MAX_DFLT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [kqvp_pkg::CHAR_W-1:0]  char_code,
	input  kqvp_pkg::cmd_t               cmd,
	output kqvp_pkg::sts_t               st,
	kqvp_pair_if.source                  pair_ch
);
	import kqvp_pkg::*;

	localparam int KC_W = $clog2(KEY_MAX + 1);
	localparam int VC_W = $clog2(VALUE_MAX + 1);
	localparam int KA_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
	localparam int VA_W = (VALUE_MAX > 1) ? $clog2(VALUE_MAX) : 1;

	logic [KC_W-1:0]   key_cnt_q;
	logic [VC_W-1:0]   val_cnt_q;
	logic              ovf_q;
	logic [KA_W-1:0]   rd_kptr_q;
	logic [VA_W-1:0]   rd_vptr_q;
	logic              rd_part_q;
	logic              key_wr, val_wr;
	logic              key_done, val_done;
	logic [CHAR_W-1:0] key_rd, val_rd;
	logic              valid_s1, part_s1, last_s1, trunc_s1;
	logic              out_valid_q, part_q, last_q, trunc_q;
	logic [CHAR_W-1:0] data_q;
	logic              move;

	// Character classification for the controller.
	assign st.is_nul    = (char_code == CH_NUL);
	assign st.is_alnum  = is_alnum(char_code);
	assign st.is_ws     = is_ws(char_code);
	assign st.is_eq     = (char_code == CH_EQUALS);
	assign st.is_quote  = (char_code == CH_QUOTE);
	assign st.is_bslash = (char_code == CH_BACKSLASH);

	// A byte is stored only while its buffer has room.
	assign key_wr = cmd.put_key && (key_cnt_q < KC_W'(KEY_MAX));
	assign val_wr = cmd.put_val && (val_cnt_q < VC_W'(VALUE_MAX));

	// Fill counts and the overflow flag of the pair in progress.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_cnt_q <= '0;
			val_cnt_q <= '0;
			ovf_q     <= 1'b0;
		end else if (cmd.clear) begin
			key_cnt_q <= '0;
			val_cnt_q <= '0;
			ovf_q     <= 1'b0;
		end else begin
			if (key_wr) begin
				key_cnt_q <= key_cnt_q + 1'b1;
			end
			if (val_wr) begin
				val_cnt_q <= val_cnt_q + 1'b1;
			end
			if ((cmd.put_key && !key_wr) || (cmd.put_val && !val_wr)) begin
				ovf_q <= 1'b1;
			end
		end
	end

	// Readout position: key bytes first, then value bytes.
	assign key_done   = ((KC_W'(rd_kptr_q) + 1'b1) == key_cnt_q);
	assign val_done   = ((VC_W'(rd_vptr_q) + 1'b1) == val_cnt_q);
	assign st.rd_last = rd_part_q ? val_done : (key_done && (val_cnt_q == '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_kptr_q <= '0;
			rd_vptr_q <= '0;
			rd_part_q <= 1'b0;
		end else if (cmd.clear) begin
			rd_kptr_q <= '0;
			rd_vptr_q <= '0;
			rd_part_q <= 1'b0;
		end else if (cmd.rd_en) begin
			if (rd_part_q) begin
				rd_vptr_q <= rd_vptr_q + 1'b1;
			end else if (key_done) begin
				rd_part_q <= 1'b1;
			end else begin
				rd_kptr_q <= rd_kptr_q + 1'b1;
			end
		end
	end

	// Key and value buffers.
	kqvp_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (KEY_MAX)
	) u_key_ram (
		.clk     (clk),
		.wr_en   (key_wr),
		.wr_addr (key_cnt_q[KA_W-1:0]),
		.wr_data (char_code),
		.rd_en   (cmd.rd_en && !rd_part_q),
		.rd_addr (rd_kptr_q),
		.rd_data (key_rd)
	);

	kqvp_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (VALUE_MAX)
	) u_val_ram (
		.clk     (clk),
		.wr_en   (val_wr),
		.wr_addr (val_cnt_q[VA_W-1:0]),
		.wr_data (char_code),
		.rd_en   (cmd.rd_en && rd_part_q),
		.rd_addr (rd_vptr_q),
		.rd_data (val_rd)
	);

	// The read stage hands its word to the output register when that is free.
	assign move       = valid_s1 && (!out_valid_q || pair_ch.ready);
	assign st.rd_free = !valid_s1 || move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.rd_en) begin
				valid_s1 <= 1'b1;
			end else if (move) begin
				valid_s1 <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (pair_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Side information travels alongside the memory read.
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			part_s1  <= rd_part_q;
			last_s1  <= st.rd_last;
			trunc_s1 <= ovf_q;
		end
		if (move) begin
			part_q  <= part_s1;
			data_q  <= part_s1 ? val_rd : key_rd;
			last_q  <= last_s1;
			trunc_q <= trunc_s1;
		end
	end

	assign pair_ch.valid     = out_valid_q;
	assign pair_ch.part      = part_q;
	assign pair_ch.data_byte = data_q;
	assign pair_ch.last      = last_q;
	assign pair_ch.truncated = trunc_q;

`ifndef NO_ASSERTIONS
	a_key_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		key_cnt_q <= KC_W'(KEY_MAX))
		else $error("key count beyond buffer size");
	a_val_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		val_cnt_q <= VC_W'(VALUE_MAX))
		else $error("value count beyond buffer size");
	a_rd_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> st.rd_free)
		else $error("buffer read issued with the read stage occupied");
	a_rd_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> (key_cnt_q != '0) && !cmd.put_key && !cmd.put_val)
		else $error("readout of an empty pair or during a store");
`endif
endmodule

[sv/key_quoted_value_list_parser_top.sv]
// Parser for settings strings of the form  key = 'value'  separated by
// whitespace, commas or other characters that are not letters or digits.
// The char_ch channel takes one string byte per word; a zero byte ends the
// string and drops any partial pair. The pair_ch channel gives one decoded
// byte per word: the key bytes (part 0), then the value bytes (part 1),
// with last on the final byte and truncated on every byte of a pair whose
// key or value was cut to the buffer size.
// While scanning, one character is accepted every cycle. On the closing
// quote the block stops taking characters while the pair is read out of
// its buffer memories, one byte per cycle while the output side has room;
// once the quote has set the readout phase, each byte passes a registered
// read stage and then an output register, and scanning resumes once the
// last byte has been read from memory.
// If the receiver stalls, the readout pauses with up to two words held;
// scanning of the next pair may proceed while they wait.
// Reset clears the phase, counts and handshake state; no clearing pass is
// needed and the block accepts characters as soon as reset is released.
module key_quoted_value_list_parser_top #(
	parameter int KEY_MAX   = kqvp_pkg::KEY_MAX_DFLT,
	parameter int VALUE_MAX = kqvp_pkg::VALUE_MAX_DFLT
) (
	input  logic        clk,
	input  logic        arst_n,
	kqvp_char_if.sink   char_ch,
	kqvp_pair_if.source pair_ch
);
	import kqvp_pkg::*;

	cmd_t cmd;
	sts_t st;

	// Phase controller.
	kqvp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_ch.valid),
		.char_ready (char_ch.ready),
		.st         (st),
		.cmd        (cmd)
	);

	// Buffers, counters and output stages.
	kqvp_dp #(
		.KEY_MAX   (KEY_MAX),
		.VALUE_MAX (VALUE_MAX)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_code (char_ch.char_code),
		.cmd       (cmd),
		.st        (st),
		.pair_ch   (pair_ch)
	);
endmodule
